// ----- rtl/core/sdc_pkg.sv -----
`default_nettype none

package sdc_pkg;

   localparam int unsigned SAMPLE_W   = 64;
   localparam int unsigned WCODE_W    = 2;
   localparam int unsigned STRIDE_W   = 5;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 5;

   // cells in the row, one per channel; also the largest legal stride
   localparam int unsigned MAX_STRIDE = 16;

   // register indexes on the configuration port
   localparam logic [CSR_ADDR_W-1:0] REG_DECODE_MODE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_WIDTH_CODE  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_STRIDE      = 2'd2;

   // sample width codes
   localparam logic [WCODE_W-1:0] WC_8  = 2'd0;
   localparam logic [WCODE_W-1:0] WC_16 = 2'd1;
   localparam logic [WCODE_W-1:0] WC_32 = 2'd2;
   localparam logic [WCODE_W-1:0] WC_64 = 2'd3;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic                step;    // item accepted this cycle
      logic                clear;   // item accepted and marked last
      logic [STRIDE_W-1:0] stride;  // channels in use
   } cell_ctl_type;

   function automatic sample_type width_mask(input logic [WCODE_W-1:0] code);
      sample_type m;
      m = '0;
      unique case (code)
         WC_8:    m[7:0]  = '1;
         WC_16:   m[15:0] = '1;
         WC_32:   m[31:0] = '1;
         WC_64:   m       = '1;
         default: m       = '1;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/strided_delta_codec.sv -----
`default_nettype none

// Strided delta encoder / decoder.
// Items arrive on the req_ stream, one sample per item in req_tdata with
// req_tlast marking the end of a buffer. Each item produces exactly one
// item on the rsp_ stream: the coded sample in rsp_tdata (bits above the
// configured width are zero) and a copy of the last flag in rsp_tlast.
// Samples go round-robin to channel_stride channels; a row of cells, one
// per channel, holds each channel's previous value and passes a channel
// token to its neighbor on each accepted item; a last item resets the row.
// Configure through csr_we / csr_addr / csr_wdata while the stream is idle:
// index 0 decode_mode, 1 width_code, 2 channel_stride (0 or values above
// MAX_STRIDE are dropped).
// A result is registered and appears the cycle after its item is accepted.
// Throughput: one item per cycle; the cell read, one 64-bit add or subtract
// and the write back to the selected cell all fit in that cycle.
// The output register accepts a new item in the same cycle the waiting
// result is taken; while rsp_tready is low with a result held, req_tready
// drops and the held result stays put.
// Reset clears all channels, points the token at channel zero and sets
// encode mode, 8-bit samples and a stride of one.
module strided_delta_codec (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [sdc_pkg::SAMPLE_W-1:0]    req_tdata,  // [63:0] sample
   input  wire logic                            req_tlast,  // last
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [sdc_pkg::SAMPLE_W-1:0]         rsp_tdata,  // [63:0] coded
   output logic                                 rsp_tlast,  // end_mark
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [sdc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [sdc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sdc_pkg::*;

   // configuration registers
   logic                decode_ff, decode_in;
   logic [WCODE_W-1:0]  wcode_ff, wcode_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;

   logic         accept;
   cell_ctl_type ctl;
   sample_type   mask, samp, prev, result, wr_data;
   logic         fallback, wrap_any;

   logic [MAX_STRIDE-1:0] tok_hit_vec, sel_vec, wrap_vec;
   sample_type            rd_bus [MAX_STRIDE+1];

   // ---------------- configuration ----------------
   always_comb begin
      decode_in = decode_ff;
      wcode_in  = wcode_ff;
      stride_in = stride_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_DECODE_MODE: decode_in = csr_wdata[0];
            REG_WIDTH_CODE:  wcode_in  = csr_wdata[WCODE_W-1:0];
            REG_STRIDE: begin
               // drop strides outside one to MAX_STRIDE
               if ((csr_wdata != '0) && (32'(csr_wdata) <= MAX_STRIDE)) begin
                  stride_in = csr_wdata;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_ff <= 1'b0;
         wcode_ff  <= WC_8;
         stride_ff <= STRIDE_W'(1);
      end else begin
         decode_ff <= decode_in;
         wcode_ff  <= wcode_in;
         stride_ff <= stride_in;
      end
   end

   // ---------------- handshake ----------------
   // advance whenever the output register is empty or being drained
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   assign ctl.step   = accept;
   assign ctl.clear  = accept & req_tlast;
   assign ctl.stride = stride_ff;

   // ---------------- cell row ----------------
   // with the token parked beyond the stride in use, channel zero takes the item
   assign fallback  = ~(|tok_hit_vec);
   assign wrap_any  = |wrap_vec;
   assign rd_bus[0] = '0;

   for (genvar k = 0; k < MAX_STRIDE; k++) begin : g_cell
      logic carry;
      logic fb;
      if (k == 0) begin : g_head
         assign carry = wrap_any;
         assign fb    = fallback;
      end else begin : g_body
         assign carry = sel_vec[k-1];
         assign fb    = 1'b0;
      end

      sdc_cell #(
         .IDX (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .carry_in    (carry),
         .fallback_in (fb),
         .wr_data     (wr_data),
         .rd_in       (rd_bus[k]),
         .tok_hit     (tok_hit_vec[k]),
         .sel         (sel_vec[k]),
         .wrap        (wrap_vec[k]),
         .rd_out      (rd_bus[k+1])
      );
   end

   // ---------------- datapath ----------------
   assign mask = width_mask(wcode_ff);
   assign samp = req_tdata & mask;
   assign prev = rd_bus[MAX_STRIDE] & mask;

   always_comb begin
      if (decode_ff) begin
         // accumulate: the reconstructed value becomes the channel's history
         result  = (samp + prev) & mask;
         wr_data = result;
      end else begin
         // difference against the previous raw sample
         result  = (samp - prev) & mask;
         wr_data = samp;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
         rsp_last_in  = req_tlast;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // exactly one channel is selected at any time
   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      $onehot(sel_vec))
      else $error("channel selection is not one-hot");

   // after the last item of a buffer the token is back at channel zero
   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (sel_vec[0] && tok_hit_vec[0]))
      else $error("token not at channel zero after last item");

   // an accepted item always leaves a result in the output register
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted item produced no result");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/sdc_cell.sv -----
`default_nettype none

module sdc_cell #(
   parameter int unsigned IDX = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sdc_pkg::cell_ctl_type ctl,
   input  wire logic                 carry_in,    // token handed on by the neighbor
   input  wire logic                 fallback_in, // take the item when no active cell has it
   input  wire sdc_pkg::sample_type  wr_data,
   input  wire sdc_pkg::sample_type  rd_in,
   output logic                      tok_hit,
   output logic                      sel,
   output logic                      wrap,
   output sdc_pkg::sample_type       rd_out
);
   import sdc_pkg::*;

   logic       token_ff, token_in;
   sample_type val_ff, val_in;
   logic       active, next_active;

   assign active      = (IDX < 32'(ctl.stride));
   assign next_active = ((IDX + 1) < 32'(ctl.stride));

   assign tok_hit = token_ff & active;
   assign sel     = tok_hit | fallback_in;
   // hand the token back to cell zero when this is the last channel in use
   assign wrap    = sel & ~next_active;

   // fold this cell's value into the read bus when it is the selected channel
   assign rd_out  = rd_in | (sel ? val_ff : '0);

   always_comb begin
      token_in = token_ff;
      val_in   = val_ff;
      if (ctl.clear) begin
         token_in = (IDX == 0);
         val_in   = '0;
      end else if (ctl.step) begin
         token_in = carry_in & active;
         if (sel) begin
            val_in = wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= (IDX == 0);
         val_ff   <= '0;
      end else begin
         token_ff <= token_in;
         val_ff   <= val_in;
      end
   end

endmodule

`default_nettype wire
